// ----- rtl/core/ifd_pkg.sv -----
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared constants and types of the receiver frame decoder.
// ----------------------------------------------------------------------------
package ifd_pkg;

   localparam int FRAME_BYTES   = 32;
   localparam int CHANNEL_SLOTS = 14;
   localparam int STORE_LEN     = FRAME_BYTES - 2;

   localparam logic [7:0]  START_BYTE = 8'h20;
   localparam logic [15:0] SUM_INIT   = 16'hFFFF;

   localparam logic [3:0]  LIVE_RESET = 4'd10;
   localparam logic [15:0] FILL_RESET = 16'd1000;

   // byte counter must hold STORE_LEN itself
   localparam int CNT_W      = $clog2(STORE_LEN + 1);
   // frame bytes are split over an even and an odd store
   localparam int HALF_DEPTH = (STORE_LEN + 1) / 2;
   localparam int HIDX_W     = $clog2(HALF_DEPTH);
   localparam int RAM_AW     = HIDX_W + 1;
   localparam int RAM_DEPTH  = 2 * (1 << HIDX_W);
   localparam int SLOT_W     = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNEL_SLOTS - 1);

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIVE_CHANNELS = 1'b0,
      CSR_FILL_VALUE    = 1'b1
   } csr_index_type;

   // checked frame handed from front to back
   typedef struct packed {
      logic drop;
      logic bank;
   } job_type;

   // write into the frame store, one byte a beat
   typedef struct packed {
      logic              en_even;
      logic              en_odd;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        data;
   } store_wr_type;

   // back is done reading a bank
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic [3:0]  channel_index;
      logic [15:0] channel_value;
      logic        frame_drop;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/core/ifd_ram.sv -----
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ifd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ifd_front.sv -----
// ----------------------------------------------------------------------------
// ifd_front
// Byte front end: start byte hunt, frame store writes, running checksum and
// the check itself. Hands one job per frame to the back end.
// ----------------------------------------------------------------------------
module ifd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_rx_byte,
   output ifd_pkg::store_wr_type store_wr,
   output ifd_pkg::job_type      job,
   output logic                  job_push,
   input  logic                  job_full,
   input  ifd_pkg::release_type  bank_release
);
   import ifd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_CK_LO,
      PH_CK_HI
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       ck_lo_ff, ck_lo_in;
   logic             bank_ff, bank_in;
   logic [1:0]       bank_busy_ff, bank_busy_in;
   logic             accept;
   logic [15:0]      ck_rx;
   logic [CNT_W-1:0] count_p1;

   // the bank being written must not still be read by the back end
   assign req_full = job_full | bank_busy_ff[bank_ff];
   assign accept   = req_push & ~req_full;
   assign ck_rx    = {req_rx_byte, ck_lo_ff};
   assign count_p1 = count_ff + CNT_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      ck_lo_in      = ck_lo_ff;
      bank_in       = bank_ff;
      bank_busy_in  = bank_busy_ff;
      job_push      = 1'b0;
      job.drop      = 1'b0;
      job.bank      = bank_ff;
      store_wr.en_even = 1'b0;
      store_wr.en_odd  = 1'b0;
      store_wr.addr    = {bank_ff, count_ff[HIDX_W:1]};
      store_wr.data    = req_rx_byte;

      if (bank_release.valid) begin
         bank_busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (req_rx_byte == START_BYTE) begin
                  store_wr.en_even = 1'b1;
                  store_wr.addr    = {bank_ff, {HIDX_W{1'b0}}};
                  count_in         = CNT_W'(1);
                  sum_in           = SUM_INIT - {8'h00, req_rx_byte};
                  phase_in         = PH_DATA;
               end
            end
            PH_DATA: begin
               store_wr.en_even = ~count_ff[0];
               store_wr.en_odd  = count_ff[0];
               sum_in           = sum_ff - {8'h00, req_rx_byte};
               count_in         = count_p1;
               if (count_p1 == CNT_W'(STORE_LEN)) begin
                  phase_in = PH_CK_LO;
               end
            end
            PH_CK_LO: begin
               ck_lo_in = req_rx_byte;
               phase_in = PH_CK_HI;
            end
            PH_CK_HI: begin
               job_push = 1'b1;
               job.drop = (ck_rx != sum_ff);
               if (ck_rx == sum_ff) begin
                  // good frame: lock its bank, move on to the other one
                  bank_busy_in[bank_ff] = 1'b1;
                  bank_in               = ~bank_ff;
               end
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         sum_ff       <= SUM_INIT;
         ck_lo_ff     <= '0;
         bank_ff      <= 1'b0;
         bank_busy_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ck_lo_ff     <= ck_lo_in;
         bank_ff      <= bank_in;
         bank_busy_ff <= bank_busy_in;
      end
   end

endmodule

// ----- rtl/core/ifd_job_fifo.sv -----
// ----------------------------------------------------------------------------
// ifd_job_fifo
// Two-entry queue of checked frames between the front and back ends.
// ----------------------------------------------------------------------------
module ifd_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ifd_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output ifd_pkg::job_type  head,
   output logic              empty
);
   import ifd_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/ifd_back.sv -----
// ----------------------------------------------------------------------------
// ifd_back
// Result back end: walks the channel slots of a good frame through the frame
// store, or emits the drop result, into a small result queue.
// Also holds the configuration registers.
// ----------------------------------------------------------------------------
module ifd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ifd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                csr_data,
   input  ifd_pkg::job_type           job,
   input  logic                       job_empty,
   output logic                       job_pop,
   output ifd_pkg::release_type       bank_release,
   output logic                       rd_en,
   output logic [ifd_pkg::RAM_AW-1:0] rd_addr,
   input  logic [7:0]                 rd_lo,
   input  logic [7:0]                 rd_hi,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output ifd_pkg::rsp_type           rsp
);
   import ifd_pkg::*;

   localparam logic [2:0] QDEPTH = 3'd4;

   logic [3:0]        live_ff;
   logic [15:0]       fill_ff;

   logic              busy_ff, busy_in;
   logic              bank_ff, bank_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // read stage, lines up with the registered store read
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_drop_ff, s1_drop_in;
   logic [3:0]        s1_index_ff, s1_index_in;
   logic              s1_last_ff, s1_last_in;
   logic              s1_fill_ff, s1_fill_in;
   logic              s1_lo_ok_ff, s1_lo_ok_in;
   logic              s1_hi_ok_ff, s1_hi_ok_in;

   rsp_type           q_ff [4];
   logic [1:0]        q_wr_ff, q_rd_ff;
   logic [2:0]        q_count_ff, q_count_in;
   logic              q_push, q_pop;
   rsp_type           q_entry;

   logic              space;
   logic [7:0]        slot_w;
   logic [7:0]        lo_pos;
   logic [7:0]        slot_p1;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= LIVE_RESET;
         fill_ff <= FILL_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LIVE_CHANNELS: live_ff <= csr_data[3:0];
            CSR_FILL_VALUE:    fill_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // credit check: queued results plus the one in flight
   assign space   = ({1'b0, q_count_ff} + {3'b000, s1_valid_ff}) < {1'b0, QDEPTH};
   assign slot_w  = 8'(slot_ff);
   assign lo_pos  = (slot_w << 1) + 8'd2;
   assign slot_p1 = slot_w + 8'd1;
   assign rd_addr = {bank_ff, slot_p1[HIDX_W-1:0]};

   always_comb begin
      busy_in      = busy_ff;
      bank_in      = bank_ff;
      slot_in      = slot_ff;
      job_pop      = 1'b0;
      rd_en        = 1'b0;
      bank_release = '0;
      s1_valid_in  = 1'b0;
      s1_drop_in   = 1'b0;
      s1_index_in  = 4'(slot_ff);
      s1_last_in   = (slot_ff == LAST_SLOT);
      s1_fill_in   = (slot_w >= {4'h0, live_ff});
      s1_lo_ok_in  = (lo_pos < 8'(STORE_LEN));
      s1_hi_ok_in  = ((lo_pos + 8'd1) < 8'(STORE_LEN));

      if (busy_ff) begin
         if (space) begin
            rd_en       = 1'b1;
            s1_valid_in = 1'b1;
            slot_in     = slot_ff + SLOT_W'(1);
            if (slot_ff == LAST_SLOT) begin
               busy_in            = 1'b0;
               bank_release.valid = 1'b1;
               bank_release.bank  = bank_ff;
            end
         end
      end else if (~job_empty) begin
         if (job.drop) begin
            if (space) begin
               job_pop     = 1'b1;
               s1_valid_in = 1'b1;
               s1_drop_in  = 1'b1;
               s1_index_in = 4'h0;
               s1_last_in  = 1'b1;
            end
         end else begin
            job_pop = 1'b1;
            busy_in = 1'b1;
            bank_in = job.bank;
            slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_drop_ff  <= s1_drop_in;
      s1_index_ff <= s1_index_in;
      s1_last_ff  <= s1_last_in;
      s1_fill_ff  <= s1_fill_in;
      s1_lo_ok_ff <= s1_lo_ok_in;
      s1_hi_ok_ff <= s1_hi_ok_in;
      bank_ff     <= bank_in;
      slot_ff     <= slot_in;
      if (reset) begin
         busy_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_comb begin
      q_entry.channel_index = s1_index_ff;
      q_entry.frame_drop    = s1_drop_ff;
      q_entry.last          = s1_last_ff;
      if (s1_drop_ff) begin
         q_entry.channel_value = 16'h0000;
      end else if (s1_fill_ff) begin
         q_entry.channel_value = fill_ff;
      end else begin
         // bytes past the stored frame read as zero
         q_entry.channel_value = {s1_hi_ok_ff ? rd_hi : 8'h00,
                                  s1_lo_ok_ff ? rd_lo : 8'h00};
      end
   end

   assign q_push    = s1_valid_ff;
   assign rsp_empty = (q_count_ff == 3'd0);
   assign q_pop     = rsp_pop & ~rsp_empty;
   assign rsp       = q_ff[q_rd_ff];

   always_comb begin
      q_count_in = q_count_ff;
      if (q_push & ~q_pop) begin
         q_count_in = q_count_ff + 3'd1;
      end else if (q_pop & ~q_push) begin
         q_count_in = q_count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_ff[q_wr_ff] <= q_entry;
      end
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + 2'd1;
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + 2'd1;
         end
         q_count_ff <= q_count_in;
      end
   end

endmodule

// ----- rtl/core/ibus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// ibus_frame_decoder
// Receiver serial frame decoder: checks each frame against its checksum and
// returns one word per channel slot, or a single drop beat on a bad frame.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   req      | req_push/req_full  | req_rx_byte
//   rsp      | rsp_empty/rsp_pop  | rsp_channel_index, rsp_channel_value,
//            |                    | rsp_frame_drop, rsp_last
//   csr      | csr_valid/csr_ready| csr_index, csr_data
//
// One byte is taken per cycle while req_full is low. After the second
// checksum byte a good frame gives its 14 slot beats at one per cycle while
// the result queue has room; the rate is set by the one read port of the
// frame store. The store is double banked: req_full rises while the next
// bank is still being read, or while the two-entry job queue is full.
// Reset is synchronous; the frame store needs no clearing.
// ----------------------------------------------------------------------------
module ibus_frame_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [3:0]                    rsp_channel_index,
   output logic [15:0]                   rsp_channel_value,
   output logic                          rsp_frame_drop,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ifd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_data
);
   import ifd_pkg::*;

   store_wr_type      store_wr;
   job_type           job_in, job_head;
   logic              job_push, job_full, job_pop, job_empty;
   release_type       bank_release;
   logic              rd_en;
   logic [RAM_AW-1:0] rd_addr;
   logic [7:0]        rd_lo, rd_hi;
   rsp_type           rsp;

   ifd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_rx_byte  (req_rx_byte),
      .store_wr     (store_wr),
      .job          (job_in),
      .job_push     (job_push),
      .job_full     (job_full),
      .bank_release (bank_release)
   );

   ifd_job_fifo u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .full     (job_full),
      .pop      (job_pop),
      .head     (job_head),
      .empty    (job_empty)
   );

   // even frame bytes carry the slot low byte, odd ones the high byte
   ifd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store_even (
      .clock   (clock),
      .wr_en   (store_wr.en_even),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_lo)
   );

   ifd_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store_odd (
      .clock   (clock),
      .wr_en   (store_wr.en_odd),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_hi)
   );

   ifd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .job          (job_head),
      .job_empty    (job_empty),
      .job_pop      (job_pop),
      .bank_release (bank_release),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_lo        (rd_lo),
      .rd_hi        (rd_hi),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp          (rsp)
   );

   assign rsp_channel_index = rsp.channel_index;
   assign rsp_channel_value = rsp.channel_value;
   assign rsp_frame_drop    = rsp.frame_drop;
   assign rsp_last          = rsp.last;

endmodule
